// File: design/psh_pkg.sv
// shared types and constants of the pc sample histogram
`default_nettype none

package psh_pkg;

    // field widths
    localparam int PC_W        = 32;
    localparam int TICK_W      = 32;
    localparam int SCALE_W     = 17;
    localparam int REGION_W    = 14;
    localparam int RIDX_W      = 12;
    localparam int BINV_W      = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    // fixed-point arithmetic
    localparam int FRAC_BITS   = 16;
    localparam int PROD_W      = PC_W + SCALE_W;
    // bin number taken from a byte offset below 2**REGION_W
    localparam int BIN_FIELD_W = REGION_W - 1;

    // queue between front and back
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);

    // operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PC_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION    = 2'd2;

    // classified item handed from front to back
    typedef struct packed {
        logic                   is_read;
        logic                   active;
        logic [BIN_FIELD_W-1:0] bin;
        logic [TICK_W-1:0]      tick;
    } psh_item_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } psh_qstat_t;

endpackage

`default_nettype wire

// File: design/psh_front.sv
// front part: configuration, tick count, offset multiply and classification
`default_nettype none

module psh_front #(
    parameter int BINS = 4096
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             op,
    input  logic [psh_pkg::PC_W-1:0]         pc,
    input  logic [psh_pkg::RIDX_W-1:0]       read_index,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [psh_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [psh_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             clearing,
    input  psh_pkg::psh_qstat_t              qstat,
    output logic                             push,
    output psh_pkg::psh_item_t               push_item
);
    import psh_pkg::*;

    logic [PC_W-1:0]        pc_offset_reg;
    logic [SCALE_W-1:0]     scale_reg;
    logic [REGION_W-1:0]    region_reg;
    logic [TICK_W-1:0]      tick_reg;
    logic [TICK_W-1:0]      tick_next;

    logic                   s1_valid_reg;
    logic                   s1_op_reg;
    logic                   s1_qual_reg;
    logic [PC_W-1:0]        s1_diff_reg;
    logic [RIDX_W-1:0]      s1_ridx_reg;
    logic [TICK_W-1:0]      s1_tick_reg;

    logic                   s2_valid_reg;
    logic                   s2_op_reg;
    logic                   s2_qual_reg;
    logic [PROD_W-1:0]      s2_prod_reg;
    logic [RIDX_W-1:0]      s2_ridx_reg;
    logic [TICK_W-1:0]      s2_tick_reg;

    logic                   advance;
    logic                   accept;
    logic [BIN_FIELD_W-1:0] cand_bin;
    logic [REGION_W-1:0]    offs_even;
    logic                   hi_zero;
    logic                   samp_hit;
    logic                   read_in_range;

    // pipeline moves unless the last stage waits on a full queue
    assign advance   = !(s2_valid_reg && qstat.full);
    assign in_stall  = clearing || !advance;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // tick count after a sample
    assign tick_next = (op == OP_SAMPLE) ? tick_reg + TICK_W'(1) : tick_reg;

    // control state, configuration and tick count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_offset_reg <= '0;
            scale_reg     <= '0;
            region_reg    <= '0;
            tick_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_PC_OFFSET: pc_offset_reg <= cfg_data[PC_W-1:0];
                    CFG_SCALE:     scale_reg     <= cfg_data[SCALE_W-1:0];
                    CFG_REGION:    region_reg    <= cfg_data[REGION_W-1:0];
                    default:       ;
                endcase
            end
            if (accept)
            begin
                tick_reg <= tick_next;
            end
            if (advance)
            begin
                s1_valid_reg <= accept;
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // payload stages: offset subtract, then scale multiply
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_op_reg   <= op;
            s1_qual_reg <= (scale_reg != '0) && (pc >= pc_offset_reg);
            s1_diff_reg <= pc - pc_offset_reg;
            s1_ridx_reg <= read_index;
            s1_tick_reg <= tick_next;

            s2_op_reg   <= s1_op_reg;
            s2_qual_reg <= s1_qual_reg;
            s2_prod_reg <= PROD_W'(s1_diff_reg) * PROD_W'(scale_reg);
            s2_ridx_reg <= s1_ridx_reg;
            s2_tick_reg <= s1_tick_reg;
        end
    end

    // byte offset with bit 0 cleared, checked against region and bin count
    assign cand_bin  = s2_prod_reg[FRAC_BITS+REGION_W-1 -: BIN_FIELD_W];
    assign offs_even = {cand_bin, 1'b0};
    assign hi_zero   = (s2_prod_reg[PROD_W-1:FRAC_BITS+REGION_W] == '0);
    assign samp_hit  = s2_qual_reg && hi_zero && (offs_even < region_reg)
                       && (32'(cand_bin) < 32'(BINS));
    assign read_in_range = (32'(s2_ridx_reg) < 32'(BINS));

    // classified item into the queue
    always_comb
    begin
        push              = s2_valid_reg && !qstat.full;
        push_item.is_read = (s2_op_reg == OP_READ);
        push_item.tick    = s2_tick_reg;
        if (s2_op_reg == OP_READ)
        begin
            push_item.active = read_in_range;
            push_item.bin    = BIN_FIELD_W'(s2_ridx_reg);
        end
        else
        begin
            push_item.active = samp_hit;
            push_item.bin    = samp_hit ? cand_bin : '0;
        end
    end

endmodule

`default_nettype wire

// File: design/psh_queue.sv
// two-entry queue between the front and back parts
`default_nettype none

module psh_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  psh_pkg::psh_item_t  push_item,
    input  logic                pop,
    output psh_pkg::psh_item_t  pop_item,
    output psh_pkg::psh_qstat_t qstat
);
    import psh_pkg::*;

    psh_item_t              entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]     wr_ptr_reg;
    logic [Q_PTR_W-1:0]     rd_ptr_reg;
    logic [Q_PTR_W:0]       count_reg;

    assign qstat.full  = (count_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign pop_item    = entry_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (Q_PTR_W+1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (Q_PTR_W+1)'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// File: design/psh_back.sv
// back part: histogram memory, clearing pass and read-modify-write
`default_nettype none

module psh_back #(
    parameter int BINS = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  psh_pkg::psh_qstat_t           qstat,
    input  psh_pkg::psh_item_t            pop_item,
    output logic                          pop,
    output logic                          clearing,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [psh_pkg::TICK_W-1:0]    tick_count,
    output logic                          hit,
    output logic [psh_pkg::RIDX_W-1:0]    bin_number,
    output logic [psh_pkg::BINV_W-1:0]    bin_value
);
    import psh_pkg::*;

    localparam int BIN_W = (BINS > 1) ? $clog2(BINS) : 1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WAIT
    } state_t;

    state_t                 state_reg;
    logic [BIN_W-1:0]       clr_reg;
    psh_item_t              work_reg;
    logic                   out_valid_reg;
    logic [TICK_W-1:0]      tick_reg;
    logic                   hit_reg;
    logic [RIDX_W-1:0]      bin_number_reg;
    logic [BINV_W-1:0]      bin_value_reg;

    logic [BINV_W-1:0]      mem [BINS];
    logic [BINV_W-1:0]      rd_data_reg;

    logic                   out_free;
    logic                   commit;
    logic                   we;
    logic [BIN_W-1:0]       waddr;
    logic [BINV_W-1:0]      wdata;
    logic [BINV_W-1:0]      new_value;

    assign out_free  = !out_valid_reg || !out_stall;
    assign pop       = (state_reg == ST_IDLE) && !qstat.empty;
    assign commit    = (state_reg == ST_WAIT) && out_free;
    assign clearing  = (state_reg == ST_CLEAR);
    assign new_value = work_reg.is_read ? rd_data_reg : rd_data_reg + BINV_W'(1);

    // single write port shared by the clearing pass and the update
    assign we    = clearing || (commit && work_reg.active && !work_reg.is_read);
    assign waddr = clearing ? clr_reg : BIN_W'(work_reg.bin);
    assign wdata = clearing ? '0 : new_value;

    // histogram memory with registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (pop)
        begin
            rd_data_reg <= mem[BIN_W'(pop_item.bin)];
        end
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // result taken and no new one behind it
            if (out_valid_reg && !out_stall && !commit)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + BIN_W'(1);
                    if (clr_reg == BIN_W'(BINS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        work_reg  <= pop_item;
                        state_reg <= ST_WAIT;
                    end
                end
                ST_WAIT:
                begin
                    if (commit)
                    begin
                        out_valid_reg  <= 1'b1;
                        tick_reg       <= work_reg.tick;
                        hit_reg        <= work_reg.active && !work_reg.is_read;
                        bin_number_reg <= work_reg.bin[RIDX_W-1:0];
                        bin_value_reg  <= work_reg.active ? new_value : '0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign tick_count = tick_reg;
    assign hit        = hit_reg;
    assign bin_number = bin_number_reg;
    assign bin_value  = bin_value_reg;

endmodule

`default_nettype wire

// File: design/pc_sample_histogram_unit.sv
// pc sample histogram: top level joining front, queue and back
//
// Input channel (in_valid / in_stall) carries op, pc and read_index; a
// transfer happens when in_valid is high and in_stall low. op = sample
// advances the tick count and may bump one 16-bit bin; op = read returns a
// bin. Every input transfer yields exactly one result on the output channel
// (out_valid / out_stall), in order. Registers pc_offset, scale and
// region_bytes are written through cfg_valid / cfg_ready / cfg_index /
// cfg_data; the user must write them only while the block is idle, which
// the block does not enforce; cfg_ready is always high. The back part
// takes a new item only once the last one is committed, set by the
// read-modify-write of the histogram memory (read, then update and write).
// Reset clears the registers and tick count, then a clearing pass writes
// zero to every bin, one per cycle; in_stall stays high during it. A
// stalled output holds its result; the front keeps taking items until the
// two-entry queue and the front pipeline fill up.
`default_nettype none

module pc_sample_histogram_unit #(
    parameter int BINS = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            op,
    input  logic [psh_pkg::PC_W-1:0]        pc,
    input  logic [psh_pkg::RIDX_W-1:0]      read_index,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [psh_pkg::TICK_W-1:0]      tick_count,
    output logic                            hit,
    output logic [psh_pkg::RIDX_W-1:0]      bin_number,
    output logic [psh_pkg::BINV_W-1:0]      bin_value,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [psh_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [psh_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import psh_pkg::*;

    psh_qstat_t qstat;
    psh_item_t  push_item;
    psh_item_t  pop_item;
    logic       push;
    logic       pop;
    logic       clearing;

    // accept, multiply and classify
    psh_front #(
        .BINS (BINS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .pc         (pc),
        .read_index (read_index),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .clearing   (clearing),
        .qstat      (qstat),
        .push       (push),
        .push_item  (push_item)
    );

    // decoupling queue
    psh_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .qstat     (qstat)
    );

    // histogram update and result
    psh_back #(
        .BINS (BINS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .qstat      (qstat),
        .pop_item   (pop_item),
        .pop        (pop),
        .clearing   (clearing),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .tick_count (tick_count),
        .hit        (hit),
        .bin_number (bin_number),
        .bin_value  (bin_value)
    );

    // no push into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !qstat.full)
        else $error("queue overflow");

    // no input transfer during the clearing pass
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !(in_valid && !in_stall))
        else $error("input taken while clearing");

    // a counted sample always names an existing bin
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && hit) |-> (32'(bin_number) < 32'(BINS)))
        else $error("hit on a bin beyond the histogram");

endmodule

`default_nettype wire
